FILE: sv/thermal_severity_classifier_top_assert.svh
// Assertion macros for the thermal severity classifier.
`ifndef THERMAL_SEVERITY_CLASSIFIER_TOP_ASSERT_SVH
`define THERMAL_SEVERITY_CLASSIFIER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication on i_clk, disabled during reset.
`define TSC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsc assertion failed");
// Next-cycle implication on i_clk, disabled during reset.
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsc assertion failed");
`else
`define TSC_ASSERT_IMPLY(label, ante, cons)
`define TSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/tsc_pkg.sv
`default_nettype none
package tsc_pkg;
    localparam int MAX_LEVELS  = 7;
    localparam int SEV_W       = 3;
    localparam int CTRL_W      = 7;
    localparam int HOT_BIT     = 6;
    localparam int HYST_W      = 20;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CTRL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HYST       = 3'd7;

    localparam logic [CTRL_W-1:0] CTRL_RESET = 7'd64;
    localparam logic [HYST_W-1:0] HYST_RESET = 20'd5000;

    typedef struct packed {
        logic [SEV_W-1:0] severity;
        logic             changed;
    } t_cls_res;
endpackage
`default_nettype wire

FILE: sv/tsc_classify.sv
`default_nettype none
module tsc_classify
    import tsc_pkg::*;
#(
    parameter int NUM_LEVELS   = 7,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic [SAMPLE_WIDTH-1:0]                 i_sample,
    input  wire logic [NUM_LEVELS-2:0][SAMPLE_WIDTH-1:0] i_thr,
    input  wire logic [CTRL_W-1:0]                       i_ctrl,
    input  wire logic [HYST_W-1:0]                       i_hyst,
    input  wire logic [SEV_W-1:0]                        i_held,
    output t_cls_res                                     o_res
);
    // Spare bits keep threshold +/- hysteresis exact.
    localparam int CMP_W = ((SAMPLE_WIDTH > HYST_W) ? SAMPLE_WIDTH : HYST_W) + 2;

    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] h_ext;
    logic                    hot;
    logic [SEV_W-1:0]        sev;

    assign s_ext = CMP_W'(signed'(i_sample));
    assign h_ext = signed'(CMP_W'(i_hyst));
    assign hot   = i_ctrl[HOT_BIT];

    // Ascending scan: the highest matching level overrides.
    always_comb begin
        logic signed [CMP_W-1:0] t_ext;
        logic                    hit;
        sev = '0;
        for (int lvl = 1; lvl < NUM_LEVELS; lvl++) begin
            t_ext = CMP_W'(signed'(i_thr[lvl-1]));
            if (i_held == SEV_W'(lvl)) begin
                t_ext = hot ? (t_ext - h_ext) : (t_ext + h_ext);
            end
            hit = hot ? (s_ext >= t_ext) : (s_ext <= t_ext);
            if (i_ctrl[lvl-1] && hit) begin
                sev = SEV_W'(lvl);
            end
        end
    end

    assign o_res.severity = sev;
    assign o_res.changed  = (sev != i_held);
endmodule
`default_nettype wire

FILE: sv/thermal_severity_classifier_top.sv
// Thermal severity classifier.
// Input stream (s_axis): one raw sensor sample per transfer, two's complement
// in the low SAMPLE_WIDTH bits of tdata. Output stream (m_axis): one result
// per sample with severity 0..NUM_LEVELS-1, the severity held before the latest
// change and a change flag.
// Config port: i_cfg_we with i_cfg_idx 0..5 writes the level thresholds,
// 6 the level enables and polarity, 7 the hysteresis; write only while idle.
// Each sample passes the input register and then the result register, which
// drives output valid. Throughput is one sample per cycle while the receiver
// accepts results: the input register feeds the compare and priority logic,
// which closes on the held level in the cycle that loads the result register.
// Reset clears the held and previous levels to 0, thresholds to 0, enables
// off with hot polarity, hysteresis 5000, and empties both registers.
// When the receiver stalls, the result register holds, the input register
// fills, and tready drops only once both are full; nothing is lost.
`default_nettype none
`include "thermal_severity_classifier_top_assert.svh"
module thermal_severity_classifier_top
    import tsc_pkg::*;
#(
    parameter int NUM_LEVELS   = 7,
    parameter int SAMPLE_WIDTH = 24,
    localparam int CFG_W       = (SAMPLE_WIDTH > HYST_W) ? SAMPLE_WIDTH : HYST_W,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS    = 2 * SEV_W + 1,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]     i_s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]         o_m_axis_tdata   // [2:0] severity,
                                                            // [5:3] prior_severity,
                                                            // [6] level_changed
);
    logic [NUM_LEVELS-2:0][SAMPLE_WIDTH-1:0] r_thr;
    logic [CTRL_W-1:0]                       r_ctrl;
    logic [HYST_W-1:0]                       r_hyst;

    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_out_valid;
    logic [SEV_W-1:0]        r_sev;
    logic [SEV_W-1:0]        r_prior;
    logic                    r_changed;
    logic [SEV_W-1:0]        r_held;
    logic [SEV_W-1:0]        r_prev;

    logic                    advance;
    logic [SEV_W-1:0]        n_prev;
    t_cls_res                cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_ctrl <= CTRL_RESET;
            r_hyst <= HYST_RESET;
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_LEVELS - 1; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_thr[k] <= i_cfg_data[SAMPLE_WIDTH-1:0];
                end
            end
            if (i_cfg_idx == REG_LEVEL_CTRL) begin
                r_ctrl <= i_cfg_data[CTRL_W-1:0];
            end
            if (i_cfg_idx == REG_HYST) begin
                r_hyst <= i_cfg_data[HYST_W-1:0];
            end
        end
    end

    tsc_classify #(
        .NUM_LEVELS   (NUM_LEVELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_classify (
        .i_sample (r_sample),
        .i_thr    (r_thr),
        .i_ctrl   (r_ctrl),
        .i_hyst   (r_hyst),
        .i_held   (r_held),
        .o_res    (cls)
    );

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign n_prev          = cls.changed ? r_held : r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_prev      <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_held      <= cls.severity;
                r_prev      <= n_prev;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_sample <= i_s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
        if (advance) begin
            r_sev     <= cls.severity;
            r_prior   <= n_prev;
            r_changed <= cls.changed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_changed, r_prior, r_sev});

    `TSC_ASSERT_IMPLY(a_sev_range, r_out_valid, r_sev <= SEV_W'(NUM_LEVELS - 1))
    `TSC_ASSERT_IMPLY(a_held_matches_out, r_out_valid, r_held == r_sev)
    `TSC_ASSERT_IMPLY(a_change_differs, r_out_valid && r_changed, r_sev != r_prior)
    `TSC_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_sample))
endmodule
`default_nettype wire
